>>> rtl/tpiir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpiir_pkg
// Shared types, constants and the microcode table of the three-phase IIR
// current loop.
// ----------------------------------------------------------------------------
package tpiir_pkg;

  localparam int unsigned NumPhases = 3;
  localparam int unsigned NumCoefs  = 8;
  localparam int unsigned SigW      = 16;  // Q5.10 signals
  localparam int unsigned CoefW     = 18;  // Q3.14 coefficients
  localparam int unsigned OpW       = 17;  // multiplier operand (holds y0 - cap)
  localparam int unsigned ProdW     = CoefW + OpW;
  localparam int unsigned AccW      = 38;  // seven Q8.24 products plus margin
  localparam int unsigned RndW      = AccW - 14;
  localparam int unsigned StepW     = 4;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned IdxW      = 4;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [SigW-1:0]  sig_t;

  // Register file reset: the H-infinity design values.
  localparam coef_t CoefReset [NumCoefs] = '{
    18'sd25608, -18'sd2076, -18'sd7153, 18'sd4668,
    -18'sd4284, -18'sd4656, 18'sd4293, 18'sd20644
  };

  // Register indexes
  localparam logic [2:0] C_FB1  = 3'd0;
  localparam logic [2:0] C_FB2  = 3'd1;
  localparam logic [2:0] C_FB3  = 3'd2;
  localparam logic [2:0] C_FF0  = 3'd3;
  localparam logic [2:0] C_FF1  = 3'd4;
  localparam logic [2:0] C_FF2  = 3'd5;
  localparam logic [2:0] C_FF3  = 3'd6;
  localparam logic [2:0] C_GAIN = 3'd7;

  localparam logic signed [AccW-1:0] RoundHalf = 38'sd8192;
  localparam logic signed [RndW-1:0] IirMax    = 24'sd10240;
  localparam logic signed [RndW-1:0] IirMin    = -24'sd10240;
  localparam logic signed [RndW-1:0] SigMax    = 24'sd32767;
  localparam logic signed [RndW-1:0] SigMin    = -24'sd32768;

  localparam logic [PhaseW-1:0] LastPhase = 2'd2;
  localparam logic [StepW-1:0]  StepFin   = 4'd13;

  typedef enum logic [2:0] {
    OP_Y1, OP_Y2, OP_Y3, OP_E0, OP_E1, OP_E2, OP_E3, OP_DIFF
  } op_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,  // step + 1
    JMP_LOOP,  // next phase from step 0, or fall through after the last
    JMP_WAIT   // hold until the output register is free, then finish
  } jmp_e;

  typedef struct packed {
    logic       mul_en;
    op_sel_e    op;
    logic [2:0] coef;
    acc_op_e    acc;
    logic       ld_err;
    logic       upd_hist;
    logic       ld_diff;
    logic       ld_ctl;
  } dp_ctl_t;

  typedef struct packed {
    dp_ctl_t dp;
    jmp_e    jmp;
  } uop_t;

  function automatic uop_t mul_uop(op_sel_e op, logic [2:0] coef, acc_op_e acc);
    uop_t u;
    u           = '0;
    u.dp.mul_en = 1'b1;
    u.dp.op     = op;
    u.dp.coef   = coef;
    u.dp.acc    = acc;
    u.jmp       = JMP_NEXT;
    return u;
  endfunction

  // Program for one phase, steps 0..12; step 13 hands off the result.
  function automatic uop_t ucode(logic [StepW-1:0] step);
    uop_t u;
    u     = '0;
    u.jmp = JMP_NEXT;
    unique case (step)
      4'd0: begin
        u           = mul_uop(OP_Y1, C_FB1, ACC_HOLD);
        u.dp.ld_err = 1'b1;
      end
      4'd1:  u = mul_uop(OP_Y2, C_FB2, ACC_LOAD);
      4'd2:  u = mul_uop(OP_Y3, C_FB3, ACC_ADD);
      4'd3:  u = mul_uop(OP_E0, C_FF0, ACC_ADD);
      4'd4:  u = mul_uop(OP_E1, C_FF1, ACC_ADD);
      4'd5:  u = mul_uop(OP_E2, C_FF2, ACC_ADD);
      4'd6:  u = mul_uop(OP_E3, C_FF3, ACC_ADD);
      4'd7:  u.dp.acc = ACC_ADD;
      4'd8:  u.dp.upd_hist = 1'b1;
      4'd9:  u.dp.ld_diff = 1'b1;
      4'd10: u = mul_uop(OP_DIFF, C_GAIN, ACC_HOLD);
      4'd11: u.dp.acc = ACC_LOAD;
      4'd12: begin
        u.dp.ld_ctl = 1'b1;
        u.jmp       = JMP_LOOP;
      end
      4'd13: u.jmp = JMP_WAIT;
      default: u.jmp = JMP_WAIT;
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tpiir_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpiir_datapath
// Shared multiply-accumulate unit, per-phase histories and result registers,
// driven one control word per cycle.
// ----------------------------------------------------------------------------
module tpiir_datapath import tpiir_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_ctl_t           dp_i,
  input  wire logic [PhaseW-1:0] phase_i,
  input  wire sig_t              tgt_i,
  input  wire sig_t              meas_i,
  input  wire sig_t              cap_i,
  input  wire coef_t             coef_i [NumCoefs],
  output sig_t                   ctl_o  [NumPhases]
);

  sig_t                     err_hist_q [NumPhases][3];
  sig_t                     out_hist_q [NumPhases][3];
  sig_t                     e0_q;
  logic signed [OpW-1:0]    diff_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q;
  sig_t                     ctl_q [NumPhases];

  logic signed [OpW-1:0]    err_raw;
  sig_t                     err_sat;
  logic signed [OpW-1:0]    op;
  logic signed [ProdW-1:0]  prod_d;
  logic signed [AccW-1:0]   acc_rnd;
  logic signed [RndW-1:0]   rnd;
  sig_t                     y0;
  sig_t                     ctl_sat;

  assign err_raw = OpW'(tgt_i) - OpW'(meas_i);
  always_comb begin
    if (err_raw > 17'sd32767)       err_sat = 16'sh7fff;
    else if (err_raw < -17'sd32768) err_sat = 16'sh8000;
    else                            err_sat = err_raw[SigW-1:0];
  end

  always_comb begin
    unique case (dp_i.op)
      OP_Y1:   op = OpW'(out_hist_q[phase_i][0]);
      OP_Y2:   op = OpW'(out_hist_q[phase_i][1]);
      OP_Y3:   op = OpW'(out_hist_q[phase_i][2]);
      OP_E0:   op = OpW'(e0_q);
      OP_E1:   op = OpW'(err_hist_q[phase_i][0]);
      OP_E2:   op = OpW'(err_hist_q[phase_i][1]);
      OP_E3:   op = OpW'(err_hist_q[phase_i][2]);
      OP_DIFF: op = diff_q;
      default: op = '0;
    endcase
  end

  assign prod_d = coef_i[dp_i.coef] * op;

  // Round half up to Q5.10, then clamp
  assign acc_rnd = acc_q + RoundHalf;
  assign rnd     = acc_rnd[AccW-1:14];

  always_comb begin
    if (rnd > IirMax)      y0 = IirMax[SigW-1:0];
    else if (rnd < IirMin) y0 = IirMin[SigW-1:0];
    else                   y0 = rnd[SigW-1:0];
  end

  always_comb begin
    if (rnd > SigMax)      ctl_sat = SigMax[SigW-1:0];
    else if (rnd < SigMin) ctl_sat = SigMin[SigW-1:0];
    else                   ctl_sat = rnd[SigW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (dp_i.mul_en) begin
      prod_q <= prod_d;
    end
    unique case (dp_i.acc)
      ACC_LOAD: acc_q <= AccW'(prod_q);
      ACC_ADD:  acc_q <= acc_q + AccW'(prod_q);
      default:  acc_q <= acc_q;
    endcase
    if (dp_i.ld_err) begin
      e0_q <= err_sat;
    end
    if (dp_i.ld_diff) begin
      diff_q <= OpW'(out_hist_q[phase_i][0]) - OpW'(cap_i);
    end
    if (dp_i.ld_ctl) begin
      ctl_q[phase_i] <= ctl_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPhases; p++) begin
        for (int k = 0; k < 3; k++) begin
          err_hist_q[p][k] <= '0;
          out_hist_q[p][k] <= '0;
        end
      end
    end else if (dp_i.upd_hist) begin
      err_hist_q[phase_i][2] <= err_hist_q[phase_i][1];
      err_hist_q[phase_i][1] <= err_hist_q[phase_i][0];
      err_hist_q[phase_i][0] <= e0_q;
      out_hist_q[phase_i][2] <= out_hist_q[phase_i][1];
      out_hist_q[phase_i][1] <= out_hist_q[phase_i][0];
      out_hist_q[phase_i][0] <= y0;
    end
  end

  assign ctl_o = ctl_q;

endmodule
`default_nettype wire

>>> rtl/three_phase_iir_current_loop.sv
`default_nettype none
// Sequencing: 13 steps per phase of one shared 18x17 multiply-accumulate unit,
//   plus a hand-off step.
// Input: a new transaction is taken only once the previous one has been handed to the output register.
// Reset (rst_ni low, asynchronous): coefficients return to their design values,
//   all error and output histories clear to zero, the sequencer goes idle.
// ----------------------------------------------------------------------------
// three_phase_iir_current_loop
// Three-phase third-order IIR current controller with capacitor-current
// active damping. A microcoded sequencer steps a single MAC datapath through
// each phase in turn; the result is held in an output register so that a new
// input transaction can be taken while it waits.
// ----------------------------------------------------------------------------
module three_phase_iir_current_loop import tpiir_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // Input stream
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata, lowest bit up: target_a, target_b, target_c, meas_current_a,
  // meas_current_b, meas_current_c, cap_current_a, cap_current_b,
  // cap_current_c (16 bits signed each)
  input  wire logic [143:0]    s_axis_tdata,
  // Output stream
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // tdata, lowest bit up: control_a, control_b, control_c (16 bits signed each)
  output logic [47:0]          m_axis_tdata,
  // Configuration writes
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [IdxW-1:0] cfg_index_i,
  input  wire logic [CoefW-1:0] cfg_data_i
);

  // ---- configuration registers --------------------------------------------
  // Writes beyond the register list are accepted and dropped.
  coef_t coef_q [NumCoefs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoefs; i++) begin
        coef_q[i] <= CoefReset[i];
      end
    end else if (cfg_valid_i && cfg_ready_o && !cfg_index_i[IdxW-1]) begin
      coef_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // ---- input capture ------------------------------------------------------
  sig_t tgt_q  [NumPhases];
  sig_t meas_q [NumPhases];
  sig_t cap_q  [NumPhases];

  logic in_acc;
  logic busy_q, busy_d;

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int p = 0; p < NumPhases; p++) begin
        tgt_q[p]  <= s_axis_tdata[p*SigW +: SigW];
        meas_q[p] <= s_axis_tdata[(p+NumPhases)*SigW +: SigW];
        cap_q[p]  <= s_axis_tdata[(p+2*NumPhases)*SigW +: SigW];
      end
    end
  end

  // ---- microcode sequencer -----------------------------------------------
  // The step counter addresses the control ROM; JMP_LOOP restarts the
  // program for the next phase, JMP_WAIT stalls until the output register
  // can take the finished transaction.
  logic [StepW-1:0]  step_q, step_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  uop_t              uop;
  dp_ctl_t           dp_ctl;
  logic              out_free;
  logic              out_load;

  assign uop      = ucode(step_q);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = busy_q && (uop.jmp == JMP_WAIT) && out_free;

  // Datapath only acts while a transaction is in flight.
  always_comb begin
    dp_ctl = uop.dp;
    if (!busy_q) begin
      dp_ctl = '0;
    end
  end

  always_comb begin
    step_d  = step_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    if (!busy_q) begin
      if (in_acc) begin
        busy_d  = 1'b1;
        step_d  = '0;
        phase_d = '0;
      end
    end else begin
      unique case (uop.jmp)
        JMP_NEXT: step_d = step_q + 1'b1;
        JMP_LOOP: begin
          if (phase_q == LastPhase) begin
            step_d = step_q + 1'b1;
          end else begin
            step_d  = '0;
            phase_d = phase_q + 1'b1;
          end
        end
        JMP_WAIT: begin
          if (out_free) begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= '0;
      phase_q <= '0;
    end else begin
      busy_q  <= busy_d;
      step_q  <= step_d;
      phase_q <= phase_d;
    end
  end

  // ---- datapath -----------------------------------------------------------
  sig_t ctl [NumPhases];

  tpiir_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dp_i    (dp_ctl),
    .phase_i (phase_q),
    .tgt_i   (tgt_q[phase_q]),
    .meas_i  (meas_q[phase_q]),
    .cap_i   (cap_q[phase_q]),
    .coef_i  (coef_q),
    .ctl_o   (ctl)
  );

  // ---- output register ----------------------------------------------------
  logic        out_vld_q;
  logic [47:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {ctl[2], ctl[1], ctl[0]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ---- assertions ---------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && step_q == '0 && phase_q == '0)
    else $error("accepted transaction did not start the program");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= StepFin && phase_q <= LastPhase)
    else $error("sequencer left the program");

  a_load_at_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> step_q == StepFin && phase_q == LastPhase)
    else $error("output loaded before all phases finished");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !busy_q && m_axis_tvalid)
    else $error("finished transaction not presented");

endmodule
`default_nettype wire

>>> tb/sv/three_phase_iir_current_loop_tb.sv
// ----------------------------------------------------------------------------
// three_phase_iir_current_loop_tb
// Self-checking bench for the three-phase IIR current loop. A queue-fed driver
// offers per-phase sample sets, a bit-true predictor of the IIR and damping
// path computes the expected controls on every accepted transaction, and a
// monitor checks each output transaction against the oldest expectation.
// Coefficient sets (design values, extremes, random) change only while idle.
// ----------------------------------------------------------------------------
module three_phase_iir_current_loop_tb import tpiir_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int          HalfPeriod     = 4;     // 8 ns clock
  localparam int          ResetCycles    = 5;
  localparam int unsigned IdlePct        = 34;    // idle chance per cycle, both sides
  localparam int unsigned CalmFrom       = 600;   // no idling between these counts
  localparam int unsigned CalmTo         = 850;
  localparam int unsigned HoldAt         = 150;   // long receiver hold-off starts here
  localparam int unsigned HoldCycles     = 600;
  localparam int unsigned RandomPhases   = 5;
  localparam int unsigned RandomPerPhase = 270;
  localparam int unsigned DrainSlack     = 50;    // margin above the input-to-output latency
  localparam int unsigned WatchdogLimit  = 5000;

  // Arithmetic
  localparam longint      RoundHalfQ14 = 8192;
  localparam int          FracBits     = 14;
  localparam longint      IirLimit     = 10240;
  localparam longint      SigHi        = 32767;
  localparam longint      SigLo        = -32768;
  localparam sig_t        SigTop       = 16'sh7FFF;
  localparam sig_t        SigBottom    = 16'sh8000;
  localparam coef_t       CoefMax      = 18'sh1FFFF;
  localparam coef_t       CoefMin      = 18'sh20000;
  localparam int unsigned IdxTop       = (1 << IdxW) - 1;
  localparam string       PhaseTag     = "abc";

  typedef sig_t [NumPhases-1:0] phase_vec_t;   // element 0 = phase a, lowest bits

  // Same layout as s_axis_tdata: targets lowest, then measured, then capacitor
  typedef struct packed {
    phase_vec_t cap;
    phase_vec_t meas;
    phase_vec_t tgt;
  } phase_sample_t;

  // --------------------------------------------------------------------------
  // DUT signals; the inputs are known from time zero
  // --------------------------------------------------------------------------
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [143:0]     s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [47:0]      m_axis_tdata;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [IdxW-1:0]  cfg_index_i   = '0;
  logic [CoefW-1:0] cfg_data_i    = '0;

  three_phase_iir_current_loop dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  phase_sample_t pending_samples[$];     // waiting to be offered
  phase_vec_t    expected_controls[$];   // predicted, waiting for the DUT
  coef_t         coef_model [NumCoefs];
  sig_t          err_hist [NumPhases][3];  // [phase][k]: error k+1 samples back
  sig_t          iir_hist [NumPhases][3];  // [phase][k]: clamped IIR output

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned coef_writes  = 0;
  int unsigned spare_writes = 0;
  int unsigned coef_sets    = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // floor((v + 0.5 LSB) / 2^14); arithmetic shift of a signed value floors
  function automatic longint round_q14(longint v);
    return (v + RoundHalfQ14) >>> FracBits;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One sample period of the loop: advances the histories, returns the controls
  function automatic phase_vec_t run_current_loop(phase_sample_t smp);
    phase_vec_t ctl_out;
    longint     err, acc, y, ctl;
    for (int p = 0; p < NumPhases; p++) begin
      err = clip(longint'(smp.tgt[p]) - longint'(smp.meas[p]), SigLo, SigHi);
      acc = longint'(coef_model[C_FB1]) * longint'(iir_hist[p][0])
          + longint'(coef_model[C_FB2]) * longint'(iir_hist[p][1])
          + longint'(coef_model[C_FB3]) * longint'(iir_hist[p][2])
          + longint'(coef_model[C_FF0]) * err
          + longint'(coef_model[C_FF1]) * longint'(err_hist[p][0])
          + longint'(coef_model[C_FF2]) * longint'(err_hist[p][1])
          + longint'(coef_model[C_FF3]) * longint'(err_hist[p][2]);
      y = clip(round_q14(acc), -IirLimit, IirLimit);
      err_hist[p][2] = err_hist[p][1];
      err_hist[p][1] = err_hist[p][0];
      err_hist[p][0] = sig_t'(err);
      iir_hist[p][2] = iir_hist[p][1];
      iir_hist[p][1] = iir_hist[p][0];
      iir_hist[p][0] = sig_t'(y);
      // y - cap spans at most 17 bits, so no wrap before the gain
      ctl = round_q14(longint'(coef_model[C_GAIN]) * (y - longint'(smp.cap[p])));
      ctl_out[p] = sig_t'(clip(ctl, SigLo, SigHi));
    end
    return ctl_out;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic sig_t corner_sig();
    case ($urandom_range(0, 5))
      0:       return SigTop;
      1:       return SigBottom;
      2:       return '0;
      3:       return '1;
      4:       return 16'sd1;
      default: return sig_t'($urandom());
    endcase
  endfunction

  function automatic phase_sample_t uniform_sample(sig_t t, sig_t m, sig_t c);
    phase_sample_t s;
    for (int p = 0; p < NumPhases; p++) begin
      s.tgt[p]  = t;
      s.meas[p] = m;
      s.cap[p]  = c;
    end
    return s;
  endfunction

  function automatic phase_sample_t corner_sample();
    phase_sample_t s;
    for (int p = 0; p < NumPhases; p++) begin
      s.tgt[p]  = corner_sig();
      s.meas[p] = corner_sig();
      s.cap[p]  = corner_sig();
    end
    return s;
  endfunction

  // Mostly tracking-error sized inputs that keep the IIR in its linear range,
  // then raw random words and saturating corners.
  function automatic phase_sample_t random_sample();
    phase_sample_t s;
    int unsigned   kind;
    kind = $urandom_range(0, 99);
    if (kind >= 80) return corner_sample();
    for (int p = 0; p < NumPhases; p++) begin
      if (kind < 55) begin
        s.tgt[p]  = sig_t'($signed($urandom_range(0, 8192)) - 4096);
        s.meas[p] = s.tgt[p] + sig_t'($signed($urandom_range(0, 1200)) - 600);
        s.cap[p]  = sig_t'($signed($urandom_range(0, 4096)) - 2048);
      end else begin
        s.tgt[p]  = sig_t'($urandom());
        s.meas[p] = sig_t'($urandom());
        s.cap[p]  = sig_t'($urandom());
      end
    end
    return s;
  endfunction

  // Near the design range most of the time, the full 18-bit range otherwise
  function automatic coef_t random_coef();
    if ($urandom_range(0, 99) < 70)
      return coef_t'($signed($urandom_range(0, 49152)) - 24576);
    return coef_t'($urandom());
  endfunction

  function automatic bit calm_window(int unsigned count);
    return count >= CalmFrom && count < CalmTo;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: offers the next pending sample set, holds it until taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_controls.push_back(run_current_loop(phase_sample_t'(s_axis_tdata)));
        items_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 &&
            (calm_window(items_sent) || $urandom_range(0, 99) >= IdlePct)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_samples.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and receiver backpressure
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    phase_vec_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = phase_vec_t'(m_axis_tdata);
        results_seen++;
        if (expected_controls.size() == 0) begin
          mismatches++;
          $display("%0t: output transaction with nothing expected, got %h", $time, got);
        end else begin
          want = expected_controls.pop_front();
          for (int p = 0; p < NumPhases; p++) begin
            if (got[p] !== want[p]) begin
              mismatches++;
              $display("%0t: control_%c expected %0d actual %0d", $time,
                       PhaseTag[p], want[p], got[p]);
            end
          end
        end
      end
      // One long hold-off while the driver keeps offering: the output register
      // fills, the sequencer parks and the input side must stall.
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (results_seen == HoldAt && !hold_done) begin
        hold_done     <= 1'b1;
        hold_left     <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm_window(results_seen) || $urandom_range(0, 99) >= IdlePct;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transaction on any channel resets the count
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, WatchdogLimit);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing tasks
  // --------------------------------------------------------------------------
  // Sender pause: everything offered, taken and answered, then latency slack.
  // Returns on a rising edge so that register writes can follow directly.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_controls.size() != 0);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  // Called on a rising edge; leaves cfg_valid_i high so writes go back to back
  task automatic write_coef(logic [IdxW-1:0] idx, coef_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < NumCoefs) begin
      coef_model[idx] = val;
      coef_writes++;
    end else begin
      spare_writes++;   // index past the register file: must not disturb it
    end
  endtask

  task automatic load_coef_set(coef_t set_vals [NumCoefs]);
    for (int i = 0; i < NumCoefs; i++) write_coef(IdxW'(i), set_vals[i]);
    write_coef(IdxW'($urandom_range(NumCoefs, IdxTop)), coef_t'($urandom()));
    cfg_valid_i <= 1'b0;
    coef_sets++;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    coef_t         set_vals [NumCoefs];
    phase_sample_t s;

    foreach (coef_model[i]) coef_model[i] = CoefReset[i];
    foreach (err_hist[p, k]) begin
      err_hist[p][k] = '0;
      iir_hist[p][k] = '0;
    end
    coef_sets = 1;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Design coefficients out of reset: error saturation both ways, a run of
    // full-scale error that winds the IIR into its clamp, capacitor extremes
    // that push the damping stage into saturation, and the way back out.
    pending_samples.push_back(uniform_sample('0, '0, '0));
    pending_samples.push_back(uniform_sample(SigTop, SigBottom, '0));
    pending_samples.push_back(uniform_sample(SigBottom, SigTop, '0));
    repeat (4) pending_samples.push_back(uniform_sample(SigTop, SigBottom, '0));
    pending_samples.push_back(uniform_sample(SigTop, SigBottom, SigBottom));
    pending_samples.push_back(uniform_sample(SigTop, SigBottom, SigTop));
    repeat (4) pending_samples.push_back(uniform_sample(SigBottom, SigTop, SigTop));
    pending_samples.push_back(uniform_sample(SigBottom, SigTop, SigBottom));
    pending_samples.push_back(uniform_sample(16'sd1024, 16'sd1000, 16'sd1));
    pending_samples.push_back(uniform_sample('1, '1, '1));
    s = uniform_sample('0, '0, '0);   // phases pulled in different directions
    s.tgt[0] = SigTop;    s.meas[0] = SigBottom;
    s.tgt[1] = SigBottom; s.meas[1] = SigTop;    s.cap[1] = SigTop;
    s.cap[2] = SigBottom;
    pending_samples.push_back(s);
    pending_samples.push_back(uniform_sample('0, '0, '0));
    wait_drained();

    // Register extremes, each followed by saturating corner traffic
    foreach (set_vals[i]) set_vals[i] = CoefMax;
    load_coef_set(set_vals);
    repeat (8) pending_samples.push_back(corner_sample());
    wait_drained();

    foreach (set_vals[i]) set_vals[i] = CoefMin;
    load_coef_set(set_vals);
    repeat (8) pending_samples.push_back(corner_sample());
    wait_drained();

    // Random part: design values first, then random coefficient sets
    for (int ph = 0; ph < RandomPhases; ph++) begin
      foreach (set_vals[i]) set_vals[i] = (ph == 0) ? CoefReset[i] : random_coef();
      load_coef_set(set_vals);
      repeat (RandomPerPhase) pending_samples.push_back(random_sample());
      wait_drained();
    end

    $display("Covered %0d input and %0d output transactions over %0d coefficient sets,",
             items_sent, results_seen, coef_sets);
    $display("with %0d register writes and %0d writes to unused indexes.",
             coef_writes, spare_writes);
    if (mismatches == 0 && expected_controls.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               expected_controls.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
